/* rtl/min_axis_second_difference_map_defines.svh */
// Assertion macros for the checker file of this block.
`ifndef MIN_AXIS_SECOND_DIFFERENCE_MAP_DEFINES_SVH
`define MIN_AXIS_SECOND_DIFFERENCE_MAP_DEFINES_SVH

// Concurrent assertion on clk_i, switched off while rst_ni is low.
`define SDMAP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A value must be zero whenever a condition holds.
`define SDMAP_ASSERT_ZERO_IF(lbl, cond, val, msg) \
  `SDMAP_ASSERT(lbl, (cond) |-> ((val) == '0), msg)

`endif

/* rtl/sdmap_pkg.sv */
package sdmap_pkg;

  // Frame and line store geometry.
  localparam int MAX_WIDTH    = 256;
  localparam int MAX_HEIGHT   = 256;
  localparam int MAX_DISTANCE = 8;
  localparam int PIXEL_BITS   = 16;
  localparam int OUT_BITS     = PIXEL_BITS + 2;

  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int STORE_ROWS  = 2 * MAX_DISTANCE;
  localparam int SLOT_W      = $clog2(STORE_ROWS);
  localparam int ADDR_W      = SLOT_W + COL_W;
  localparam int STORE_DEPTH = STORE_ROWS * MAX_WIDTH;
  localparam int TAP_W       = $clog2(MAX_DISTANCE);

  // Register widths and reset values.
  localparam int SIZE_W     = 9;
  localparam int DIST_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [SIZE_W-1:0] RST_FRAME_WIDTH  = SIZE_W'(256);
  localparam logic [SIZE_W-1:0] RST_FRAME_HEIGHT = SIZE_W'(192);
  localparam logic [DIST_W-1:0] RST_DISTANCE     = DIST_W'(8);

  // Stream word layouts.
  localparam int IN_DATA_W   = 16;
  localparam int OUT_ROW_W   = 8;
  localparam int OUT_COL_W   = 8;
  localparam int OUT_ROW_LSB = OUT_BITS;
  localparam int OUT_COL_LSB = OUT_BITS + OUT_ROW_W;
  localparam int OUT_DATA_W  = 40;
  localparam int OUT_PAD_W   = OUT_DATA_W - OUT_BITS - OUT_ROW_W - OUT_COL_W;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_DISTANCE     = 2'd2
  } cfg_index_e;

  // Clamp a frame size to 1..hi.
  function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v,
                                                    logic [SIZE_W-1:0] hi);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Magnitude of a signed result, as an unsigned value of the same width.
  function automatic logic [OUT_BITS-1:0] magnitude(logic signed [OUT_BITS-1:0] v);
    logic [OUT_BITS-1:0] r;
    if (v[OUT_BITS-1]) begin
      r = OUT_BITS'(-v);
    end else begin
      r = OUT_BITS'(v);
    end
    return r;
  endfunction

endpackage

/* rtl/min_axis_second_difference_map.sv */
// Channel   Direction  tdata (low bit up)                     tuser / tlast
// s_axis    in         pixel_value[15:0]                      tuser: start_of_frame
// m_axis    out        diff_value[17:0], out_row[25:18],      tlast: last_of_frame
//                      out_col[33:26], zero pad[39:34]
// cfg       in         cfg_index_i selects the register, cfg_wdata_i is written
//
// One word per cycle while m_axis does not stall; after its input word is taken, a
// result passes the address stage, line store read, add stage, then the select
// into the output register before it shows on m_axis.
// Reset clears the counters, the stage valid bits and restores the register
// defaults; the line store is not cleared. Back-pressure on m_axis moves stage by
// stage, so input words keep flowing while bubbles remain in the pipe.
module min_axis_second_difference_map
  import sdmap_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // pixel_value
  input  logic                  s_axis_tuser,  // start_of_frame
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // diff_value, out_row, out_col, pad
  output logic                  m_axis_tlast
);

  // Configuration registers, clamped when written.
  logic [SIZE_W-1:0] width_q, height_q;
  logic [DIST_W-1:0] dist_q;
  logic [DIST_W-1:0] dist_raw;
  logic [DIST_W-1:0] dist_clamped;

  assign dist_raw = cfg_wdata_i[DIST_W-1:0];

  always_comb begin
    if (dist_raw == '0) begin
      dist_clamped = DIST_W'(1);
    end else if (dist_raw > DIST_W'(MAX_DISTANCE)) begin
      dist_clamped = DIST_W'(MAX_DISTANCE);
    end else begin
      dist_clamped = dist_raw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_FRAME_WIDTH;
      height_q <= RST_FRAME_HEIGHT;
      dist_q   <= RST_DISTANCE;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_FRAME_WIDTH:  width_q  <= clamp_size(cfg_wdata_i, SIZE_W'(MAX_WIDTH));
        CFG_FRAME_HEIGHT: height_q <= clamp_size(cfg_wdata_i, SIZE_W'(MAX_HEIGHT));
        CFG_DISTANCE:     dist_q   <= dist_clamped;
        default: ;
      endcase
    end
  end

  // Stage advance enables, from the output back to the input.
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic en1, en2, en3, en_out;
  logic in_fire;

  assign en_out        = !out_valid_q || m_axis_tready;
  assign en3           = !s3_valid_q || en_out;
  assign en2           = !s2_valid_q || en3;
  assign en1           = !s1_valid_q || en2;
  assign s_axis_tready = en1;
  assign in_fire       = s_axis_tvalid && en1;

  // Raster counters: position of the incoming word and position of the next one.
  logic [COL_W-1:0]  col_q, col_d, cur_col;
  logic [ROW_W-1:0]  row_q, row_d, cur_row;
  logic [SIZE_W-1:0] col_inc, row_inc;
  logic              restart, col_wrap, in_last;

  always_comb begin
    restart = s_axis_tuser || (SIZE_W'(col_q) >= width_q) || (SIZE_W'(row_q) >= height_q);
    cur_row = restart ? '0 : row_q;
    cur_col = restart ? '0 : col_q;
    col_inc = SIZE_W'(cur_col) + SIZE_W'(1);
    row_inc = SIZE_W'(cur_row) + SIZE_W'(1);
    col_wrap = col_inc >= width_q;
    in_last  = (row_inc == height_q) && (col_inc == width_q);
    col_d = col_wrap ? '0 : col_inc[COL_W-1:0];
    if (!col_wrap) begin
      row_d = cur_row;
    end else if (row_inc >= height_q) begin
      row_d = '0;
    end else begin
      row_d = row_inc[ROW_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Stage 1: position and pixel of the accepted word.
  logic [ROW_W-1:0]      s1_row_q;
  logic [COL_W-1:0]      s1_col_q;
  logic [PIXEL_BITS-1:0] s1_pix_q;
  logic                  s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en1) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_row_q  <= cur_row;
      s1_col_q  <= cur_col;
      s1_pix_q  <= s_axis_tdata[PIXEL_BITS-1:0];
      s1_last_q <= in_last;
    end
  end

  // Output position, border test and line store addresses.
  logic [ROW_W-1:0]  s1_orow, s1_uprow;
  logic [COL_W-1:0]  s1_right_col, s1_left_col;
  logic              s1_emit, s1_interior;
  logic [ADDR_W-1:0] wr_addr, mid_addr, right_addr, up_addr, left_addr;
  logic              st2_load;

  always_comb begin
    s1_emit      = s1_row_q >= ROW_W'(dist_q);
    s1_orow      = s1_row_q - ROW_W'(dist_q);
    s1_uprow     = s1_orow - ROW_W'(dist_q);
    s1_right_col = s1_col_q + COL_W'(dist_q);
    s1_left_col  = s1_col_q - COL_W'(dist_q);
    s1_interior  = (s1_orow >= ROW_W'(dist_q)) && (s1_col_q >= COL_W'(dist_q)) &&
                   ((SIZE_W'(s1_col_q) + SIZE_W'(dist_q)) < width_q);
    wr_addr      = {s1_row_q[SLOT_W-1:0], s1_col_q};
    mid_addr     = {s1_orow[SLOT_W-1:0], s1_col_q};
    right_addr   = {s1_orow[SLOT_W-1:0], s1_right_col};
    up_addr      = {s1_uprow[SLOT_W-1:0], s1_col_q};
    left_addr    = {s1_orow[SLOT_W-1:0], s1_left_col};
  end

  assign st2_load = s1_valid_q && en2;

  // Line store, held twice so that four neighbors can be read in the same cycle.
  // The write of a word lands before any later word reads.
  logic [PIXEL_BITS-1:0] line_mem_a [STORE_DEPTH];
  logic [PIXEL_BITS-1:0] line_mem_b [STORE_DEPTH];
  logic [PIXEL_BITS-1:0] mid_rd_q, right_rd_q, up_rd_q, left_rd_q;

  always_ff @(posedge clk_i) begin
    if (st2_load) begin
      line_mem_a[wr_addr] <= s1_pix_q;
      mid_rd_q            <= line_mem_a[mid_addr];
      right_rd_q          <= line_mem_a[right_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (st2_load) begin
      line_mem_b[wr_addr] <= s1_pix_q;
      up_rd_q             <= line_mem_b[up_addr];
      left_rd_q           <= line_mem_b[left_addr];
    end
  end

  // Stage 2: store reads come back here.
  logic                  s2_emit_q, s2_interior_q, s2_last_q;
  logic [ROW_W-1:0]      s2_orow_q;
  logic [COL_W-1:0]      s2_col_q;
  logic [PIXEL_BITS-1:0] s2_pix_q;
  logic                  s2_leave;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en2) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st2_load) begin
      s2_emit_q     <= s1_emit;
      s2_interior_q <= s1_interior;
      s2_last_q     <= s1_last_q;
      s2_orow_q     <= s1_orow;
      s2_col_q      <= s1_col_q;
      s2_pix_q      <= s1_pix_q;
    end
  end

  assign s2_leave = s2_valid_q && en3;

  // Both second differences, exact in the wider result width.
  logic signed [OUT_BITS-1:0] mid_x, up_x, right_x, left_x, pix_x;
  logic signed [OUT_BITS-1:0] vert_d, hori_d;

  always_comb begin
    mid_x   = {{(OUT_BITS-PIXEL_BITS){mid_rd_q[PIXEL_BITS-1]}}, mid_rd_q};
    up_x    = {{(OUT_BITS-PIXEL_BITS){up_rd_q[PIXEL_BITS-1]}}, up_rd_q};
    right_x = {{(OUT_BITS-PIXEL_BITS){right_rd_q[PIXEL_BITS-1]}}, right_rd_q};
    left_x  = {{(OUT_BITS-PIXEL_BITS){left_rd_q[PIXEL_BITS-1]}}, left_rd_q};
    pix_x   = {{(OUT_BITS-PIXEL_BITS){s2_pix_q[PIXEL_BITS-1]}}, s2_pix_q};
    vert_d  = (mid_x <<< 1) - up_x - pix_x;
    hori_d  = (mid_x <<< 1) - right_x - left_x;
  end

  // Stage 3: only words that produce a result go on.
  logic signed [OUT_BITS-1:0] s3_vert_q, s3_hori_q;
  logic                       s3_interior_q, s3_last_q;
  logic [ROW_W-1:0]           s3_orow_q;
  logic [COL_W-1:0]           s3_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en3) begin
      s3_valid_q <= s2_valid_q && s2_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_leave) begin
      s3_vert_q     <= vert_d;
      s3_hori_q     <= hori_d;
      s3_interior_q <= s2_interior_q;
      s3_last_q     <= s2_last_q;
      s3_orow_q     <= s2_orow_q;
      s3_col_q      <= s2_col_q;
    end
  end

  // Pick the weaker axis; a tie goes to the horizontal one. Borders are zero.
  logic signed [OUT_BITS-1:0] diff_d;

  always_comb begin
    if (!s3_interior_q) begin
      diff_d = '0;
    end else if (magnitude(s3_vert_q) < magnitude(s3_hori_q)) begin
      diff_d = s3_vert_q;
    end else begin
      diff_d = s3_hori_q;
    end
  end

  // Output register.
  logic signed [OUT_BITS-1:0] out_diff_q;
  logic [OUT_ROW_W-1:0]       out_row_q;
  logic [OUT_COL_W-1:0]       out_col_q;
  logic                       out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_out) begin
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_valid_q && en_out) begin
      out_diff_q <= diff_d;
      out_row_q  <= OUT_ROW_W'(s3_orow_q);
      out_col_q  <= OUT_COL_W'(s3_col_q);
      out_last_q <= s3_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_col_q, out_row_q, out_diff_q};
  assign m_axis_tlast  = out_last_q;

endmodule

/* rtl/sdmap_checker.sv */
`include "min_axis_second_difference_map_defines.svh"

// Watches the result stream of the second difference map.
module sdmap_checker
  import sdmap_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tlast
);

  // A stalled result word holds its contents.
  `SDMAP_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result word changed while stalled")

  // The first column always lies inside the left border.
  `SDMAP_ASSERT_ZERO_IF(a_left_border, m_axis_tvalid && (m_axis_tdata[OUT_COL_LSB +: OUT_COL_W] == '0), m_axis_tdata[OUT_BITS-1:0], "nonzero result in left border")

  // The first output row always lies inside the top border.
  `SDMAP_ASSERT_ZERO_IF(a_top_border, m_axis_tvalid && (m_axis_tdata[OUT_ROW_LSB +: OUT_ROW_W] == '0), m_axis_tdata[OUT_BITS-1:0], "nonzero result in top border")

  // The pad bits above the fields stay clear.
  `SDMAP_ASSERT_ZERO_IF(a_pad_clear, m_axis_tvalid, m_axis_tdata[OUT_DATA_W-1:OUT_DATA_W-OUT_PAD_W], "pad bits set in result word")

endmodule

bind min_axis_second_difference_map sdmap_checker u_sdmap_checker (.*);
